>>> rtl/aabb_tpo_pkg.sv
// ============================================================================
// aabb_tpo_pkg
// Shared types, constants and helpers for the tile push-out pipeline.
// ============================================================================
package aabb_tpo_pkg;

    // Coordinate format: signed fixed point, 8 fraction bits
    localparam int COORD_BITS = 24;
    localparam int SIZE_BITS  = COORD_BITS - 1;
    localparam int BOX_BITS   = COORD_BITS + 1;
    localparam int WIDE_BITS  = COORD_BITS + 2;

    // APB register file
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [SIZE_BITS-1:0]  len_t;
    typedef logic signed [BOX_BITS-1:0]   box_t;
    typedef logic signed [WIDE_BITS-1:0]  wide_t;

    typedef enum logic [1:0] {
        REG_OFFSET_X,
        REG_OFFSET_Y,
        REG_BOX_W,
        REG_BOX_H
    } reg_idx_t;

    // Input item kinds
    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_TILE  = 1'b1;

    // Axis codes
    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic   cmd;
        coord_t mover_x;
        coord_t mover_y;
        len_t   mover_w;
        len_t   mover_h;
        coord_t tile_x;
        coord_t tile_y;
        len_t   tile_w;
        len_t   tile_h;
        logic   tile_solid;
    } in_t;

    typedef struct packed {
        coord_t pos_x;
        coord_t pos_y;
        logic   hit;
        logic   moved_axis;
    } out_t;

    typedef struct packed {
        coord_t off_x;
        coord_t off_y;
        len_t   box_w;
        len_t   box_h;
    } cfg_t;

    // Stage 1: accepted item with the pass box snapshot
    typedef struct packed {
        logic   cmd;
        logic   solid;
        coord_t px;
        coord_t py;
        len_t   tw;
        len_t   th;
        box_t   bx;
        box_t   by;
        len_t   ew;
        len_t   eh;
    } s1_t;

    // Stage 2: edge sums
    typedef struct packed {
        logic   cmd;
        logic   solid;
        coord_t px;
        coord_t py;
        wide_t  bx;
        wide_t  by;
        wide_t  ex;
        wide_t  ey;
        wide_t  tex;
        wide_t  tey;
        wide_t  lo_x;
        wide_t  lo_y;
    } s2_t;

    // Stage 3: touch test, overlap bounds, push targets
    typedef struct packed {
        logic   cmd;
        logic   solid;
        logic   touch;
        coord_t px;
        coord_t py;
        wide_t  min_x;
        wide_t  max_x;
        wide_t  min_y;
        wide_t  max_y;
        wide_t  cand_x;
        wide_t  cand_y;
    } s3_t;

    // Stage 4: overlaps and saturated targets
    typedef struct packed {
        logic   cmd;
        logic   hit;
        coord_t px;
        coord_t py;
        wide_t  ov_x;
        wide_t  ov_y;
        coord_t new_x;
        coord_t new_y;
    } s4_t;

    function automatic wide_t sx_coord(coord_t c);
        return wide_t'(c);
    endfunction

    function automatic wide_t zx_len(len_t s);
        return wide_t'(s);
    endfunction

    function automatic coord_t sat_coord(wide_t v);
        coord_t r;
        if (v > sx_coord(COORD_MAX))
            r = COORD_MAX;
        else if (v < sx_coord(COORD_MIN))
            r = COORD_MIN;
        else
            r = v[COORD_BITS-1:0];
        return r;
    endfunction

endpackage

>>> rtl/aabb_tpo_regs.sv
// ============================================================================
// aabb_tpo_regs
// APB register file: box offsets and configured box size.
// ============================================================================
module aabb_tpo_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [aabb_tpo_pkg::APB_AW-1:0]   paddr,
    input  logic [aabb_tpo_pkg::APB_DW-1:0]   pwdata,
    output logic [aabb_tpo_pkg::APB_DW-1:0]   prdata,
    output logic                              pready,
    output aabb_tpo_pkg::cfg_t                cfg
);
    import aabb_tpo_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_OFFSET_X: cfg_reg.off_x <= pwdata[COORD_BITS-1:0];
                REG_OFFSET_Y: cfg_reg.off_y <= pwdata[COORD_BITS-1:0];
                REG_BOX_W:    cfg_reg.box_w <= pwdata[SIZE_BITS-1:0];
                REG_BOX_H:    cfg_reg.box_h <= pwdata[SIZE_BITS-1:0];
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (idx)
            REG_OFFSET_X: prdata = APB_DW'(cfg_reg.off_x);
            REG_OFFSET_Y: prdata = APB_DW'(cfg_reg.off_y);
            REG_BOX_W:    prdata = APB_DW'(cfg_reg.box_w);
            REG_BOX_H:    prdata = APB_DW'(cfg_reg.box_h);
        endcase
    end

endmodule

>>> rtl/aabb_tpo_front.sv
// ============================================================================
// aabb_tpo_front
// Input stage: takes items, keeps the pass box, tags tiles with it.
// ============================================================================
module aabb_tpo_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  aabb_tpo_pkg::cfg_t   cfg,
    input  logic                 in_valid,
    input  aabb_tpo_pkg::in_t    in_data,
    output logic                 in_stall,
    output logic                 s1_valid,
    output aabb_tpo_pkg::s1_t    s1_data,
    input  logic                 s1_ready
);
    import aabb_tpo_pkg::*;

    logic s1_valid_reg;
    s1_t  s1_reg;
    logic accept;
    logic use_mover;

    // Pass state latched by a begin item
    box_t bx_reg, bx_next;
    box_t by_reg, by_next;
    len_t ew_reg, ew_next;
    len_t eh_reg, eh_next;

    assign in_stall = s1_valid_reg && !s1_ready;
    assign accept   = in_valid && !in_stall;
    assign s1_valid = s1_valid_reg;
    assign s1_data  = s1_reg;

    // Box size select and start box corner
    always_comb
    begin
        use_mover = (cfg.box_w == '0) && (cfg.box_h == '0);
        ew_next   = use_mover ? in_data.mover_w : cfg.box_w;
        eh_next   = use_mover ? in_data.mover_h : cfg.box_h;
        bx_next   = box_t'(in_data.mover_x) + box_t'(cfg.off_x);
        by_next   = box_t'(in_data.mover_y) + box_t'(cfg.off_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bx_reg <= '0;
            by_reg <= '0;
            ew_reg <= '0;
            eh_reg <= '0;
        end
        else if (accept && (in_data.cmd == CMD_BEGIN))
        begin
            bx_reg <= bx_next;
            by_reg <= by_next;
            ew_reg <= ew_next;
            eh_reg <= eh_next;
        end
    end

    // Stage 1 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    // Stage 1 payload; a tile carries the box of the latest begin
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.cmd   <= in_data.cmd;
            s1_reg.solid <= in_data.tile_solid;
            s1_reg.px    <= (in_data.cmd == CMD_BEGIN) ? in_data.mover_x : in_data.tile_x;
            s1_reg.py    <= (in_data.cmd == CMD_BEGIN) ? in_data.mover_y : in_data.tile_y;
            s1_reg.tw    <= in_data.tile_w;
            s1_reg.th    <= in_data.tile_h;
            s1_reg.bx    <= bx_reg;
            s1_reg.by    <= by_reg;
            s1_reg.ew    <= ew_reg;
            s1_reg.eh    <= eh_reg;
        end
    end

endmodule

>>> rtl/aabb_tpo_geom.sv
// ============================================================================
// aabb_tpo_geom
// Three-stage overlap datapath: edge sums, touch test, overlap and targets.
// ============================================================================
module aabb_tpo_geom
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  aabb_tpo_pkg::cfg_t   cfg,
    input  logic                 s1_valid,
    input  aabb_tpo_pkg::s1_t    s1_data,
    output logic                 s1_ready,
    output logic                 s4_valid,
    output aabb_tpo_pkg::s4_t    s4_data,
    input  logic                 s4_ready
);
    import aabb_tpo_pkg::*;

    logic s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s2_ready, s3_ready;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    s4_t  s4_reg, s4_next;

    // Each stage moves when the next one is empty or moving
    assign s3_ready = !s4_valid_reg || s4_ready;
    assign s2_ready = !s3_valid_reg || s3_ready;
    assign s1_ready = !s2_valid_reg || s2_ready;
    assign s4_valid = s4_valid_reg;
    assign s4_data  = s4_reg;

    // Stage 2: far edges and low push target before offset
    always_comb
    begin
        s2_next.cmd   = s1_data.cmd;
        s2_next.solid = s1_data.solid;
        s2_next.px    = s1_data.px;
        s2_next.py    = s1_data.py;
        s2_next.bx    = wide_t'(s1_data.bx);
        s2_next.by    = wide_t'(s1_data.by);
        s2_next.ex    = wide_t'(s1_data.bx) + zx_len(s1_data.ew);
        s2_next.ey    = wide_t'(s1_data.by) + zx_len(s1_data.eh);
        s2_next.tex   = sx_coord(s1_data.px) + zx_len(s1_data.tw);
        s2_next.tey   = sx_coord(s1_data.py) + zx_len(s1_data.th);
        s2_next.lo_x  = sx_coord(s1_data.px) - zx_len(s1_data.ew);
        s2_next.lo_y  = sx_coord(s1_data.py) - zx_len(s1_data.eh);
    end

    // Stage 3: inclusive touch test, overlap bounds, side pick
    always_comb
    begin
        wide_t tx;
        wide_t ty;
        tx = sx_coord(s2_reg.px);
        ty = sx_coord(s2_reg.py);
        s3_next.cmd    = s2_reg.cmd;
        s3_next.solid  = s2_reg.solid;
        s3_next.px     = s2_reg.px;
        s3_next.py     = s2_reg.py;
        s3_next.touch  = (s2_reg.ex >= tx) && (s2_reg.tex >= s2_reg.bx) &&
                         (s2_reg.ey >= ty) && (s2_reg.tey >= s2_reg.by);
        s3_next.min_x  = (s2_reg.ex < s2_reg.tex) ? s2_reg.ex : s2_reg.tex;
        s3_next.max_x  = (s2_reg.bx > tx) ? s2_reg.bx : tx;
        s3_next.min_y  = (s2_reg.ey < s2_reg.tey) ? s2_reg.ey : s2_reg.tey;
        s3_next.max_y  = (s2_reg.by > ty) ? s2_reg.by : ty;
        s3_next.cand_x = ((s2_reg.bx < tx) ? s2_reg.lo_x : s2_reg.tex)
                         - sx_coord(cfg.off_x);
        s3_next.cand_y = ((s2_reg.by < ty) ? s2_reg.lo_y : s2_reg.tey)
                         - sx_coord(cfg.off_y);
    end

    // Stage 4: overlap widths and saturated targets
    always_comb
    begin
        s4_next.cmd   = s3_reg.cmd;
        s4_next.hit   = (s3_reg.cmd == CMD_TILE) && s3_reg.solid && s3_reg.touch;
        s4_next.px    = s3_reg.px;
        s4_next.py    = s3_reg.py;
        s4_next.ov_x  = s3_reg.min_x - s3_reg.max_x;
        s4_next.ov_y  = s3_reg.min_y - s3_reg.max_y;
        s4_next.new_x = sat_coord(s3_reg.cand_x);
        s4_next.new_y = sat_coord(s3_reg.cand_y);
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s2_valid_reg <= s1_valid;
            if (s2_ready)
                s3_valid_reg <= s2_valid_reg;
            if (s3_ready)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s1_ready && s1_valid)
            s2_reg <= s2_next;
        if (s2_ready && s2_valid_reg)
            s3_reg <= s3_next;
        if (s3_ready && s3_valid_reg)
            s4_reg <= s4_next;
    end

endmodule

>>> rtl/aabb_tpo_resolve.sv
// ============================================================================
// aabb_tpo_resolve
// Output stage: picks the push axis, updates the mover position.
// ============================================================================
module aabb_tpo_resolve
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s4_valid,
    input  aabb_tpo_pkg::s4_t    s4_data,
    output logic                 s4_ready,
    output logic                 out_valid,
    output aabb_tpo_pkg::out_t   out_data,
    input  logic                 out_stall
);
    import aabb_tpo_pkg::*;

    logic   out_valid_reg;
    logic   hit_reg, hit_next;
    logic   axis_reg, axis_next;
    coord_t cur_x_reg, cur_x_next;
    coord_t cur_y_reg, cur_y_next;
    logic   load;

    assign s4_ready  = !out_valid_reg || !out_stall;
    assign load      = s4_valid && s4_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = '{pos_x: cur_x_reg, pos_y: cur_y_reg,
                         hit: hit_reg, moved_axis: axis_reg};

    // Smaller overlap wins; a tie goes to y
    always_comb
    begin
        hit_next   = s4_data.hit;
        axis_next  = AXIS_X;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        if (s4_data.cmd == CMD_BEGIN)
        begin
            cur_x_next = s4_data.px;
            cur_y_next = s4_data.py;
        end
        else if (s4_data.hit)
        begin
            if (s4_data.ov_x < s4_data.ov_y)
            begin
                axis_next  = AXIS_X;
                cur_x_next = s4_data.new_x;
            end
            else
            begin
                axis_next  = AXIS_Y;
                cur_y_next = s4_data.new_y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            axis_reg      <= AXIS_X;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
        end
        else
        begin
            if (s4_ready)
                out_valid_reg <= s4_valid;
            if (load)
            begin
                hit_reg   <= hit_next;
                axis_reg  <= axis_next;
                cur_x_reg <= cur_x_next;
                cur_y_reg <= cur_y_next;
            end
        end
    end

endmodule

>>> rtl/aabb_tile_push_out_unit.sv
// ============================================================================
// aabb_tile_push_out_unit
// Pushes an axis-aligned box out of solid tiles, one tile per cycle while in_stall is low.
// ============================================================================
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | input     | in_valid / in_stall  | in_data  (begin or tile item)
//  out     | output    | out_valid / out_stall| out_data (position, hit, axis)
//  apb     | input     | psel/penable/pready  | paddr, pwdata, prdata
//
//  One item per cycle while in_stall is low; a result passes through the five
//  register stages front, geom (3), resolve before it shows on out_valid.
//  Every stage moves on its own when the next one is free, so bubbles close
//  up and a stall on out loses and repeats nothing; in_stall rises only
//  when all stages are full. Reset clears the pass box, position and valids.
//
module aabb_tile_push_out_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  aabb_tpo_pkg::in_t                 in_data,
    output logic                              in_stall,
    output logic                              out_valid,
    output aabb_tpo_pkg::out_t                out_data,
    input  logic                              out_stall,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [aabb_tpo_pkg::APB_AW-1:0]   paddr,
    input  logic [aabb_tpo_pkg::APB_DW-1:0]   pwdata,
    output logic [aabb_tpo_pkg::APB_DW-1:0]   prdata,
    output logic                              pready
);
    import aabb_tpo_pkg::*;

    cfg_t cfg;
    logic s1_valid, s1_ready;
    s1_t  s1_data;
    logic s4_valid, s4_ready;
    s4_t  s4_data;

    aabb_tpo_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    aabb_tpo_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_data  (in_data),
        .in_stall (in_stall),
        .s1_valid (s1_valid),
        .s1_data  (s1_data),
        .s1_ready (s1_ready)
    );

    aabb_tpo_geom u_geom
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s1_valid (s1_valid),
        .s1_data  (s1_data),
        .s1_ready (s1_ready),
        .s4_valid (s4_valid),
        .s4_data  (s4_data),
        .s4_ready (s4_ready)
    );

    aabb_tpo_resolve u_resolve
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s4_valid  (s4_valid),
        .s4_data   (s4_data),
        .s4_ready  (s4_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_stall (out_stall)
    );

    // Back-pressure reaches the input only through a full pipe
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid && s4_valid && out_valid && out_stall))
        else $error("input stalled while the pipeline has room");

    // A tile that misses leaves the position alone
    a_miss_keeps_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid && s4_ready && (s4_data.cmd == CMD_TILE) && !s4_data.hit)
        |=> ($stable(out_data.pos_x) && $stable(out_data.pos_y)))
        else $error("position moved on a tile without a hit");

    // A push along x never touches y
    a_x_push_keeps_y: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid && s4_ready && s4_data.hit && (s4_data.ov_x < s4_data.ov_y))
        |=> ($stable(out_data.pos_y) && (out_data.moved_axis == AXIS_X)))
        else $error("x push changed y or reported the wrong axis");

endmodule

>>> bench/aabb_tile_push_out_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// aabb_tile_push_out_unit_tb
// Self-checking bench for the tile push-out unit. Directed begin/tile items
// cover the extremes, edge contact, overlap ties and saturation. Random
// passes place tiles around the latched start box under several register
// settings, with sender bursts, receiver stalls and repeated long output holds.
// Every result transfer is checked field by field against an in-bench model.
// ============================================================================
module aabb_tile_push_out_unit_tb;
    import aabb_tpo_pkg::*;

    localparam len_t LEN_MAX     = '1;
    localparam int   MOVER_SPAN  = 1 << 20;
    localparam int   DRAIN_CYCLES = 8;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_LONG_HOLD} rx_mode_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    in_t                 in_data;
    logic                in_stall;
    logic                out_valid;
    out_t                out_data;
    logic                out_stall;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // Register copies and pass state of the position model
    coord_t   cfg_off_x = '0;
    coord_t   cfg_off_y = '0;
    len_t     cfg_box_w = '0;
    len_t     cfg_box_h = '0;
    longint   pass_box_x = 0;
    longint   pass_box_y = 0;
    len_t     pass_w = '0;
    len_t     pass_h = '0;
    coord_t   cur_x = '0;
    coord_t   cur_y = '0;

    out_t     resolved_q[$];
    int       mismatch_count = 0;
    int       gap_max = 0;
    int       burst_left = 1;
    int       tiles_left = 0;
    rx_mode_t rx_mode = RX_OPEN;

    aabb_tile_push_out_unit DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_stall (out_stall),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Position model
    // ------------------------------------------------------------------------
    function automatic longint as_long(coord_t c);
        return longint'(c);
    endfunction

    function automatic coord_t clamp_coord(longint v);
        if (v > as_long(COORD_MAX))
            return COORD_MAX;
        if (v < as_long(COORD_MIN))
            return COORD_MIN;
        return coord_t'(v);
    endfunction

    function automatic out_t resolve_item(in_t it);
        out_t   r;
        longint tx, ty, tw, th, bx, by, ew, eh, ovx, ovy, lo, hi;
        r = '0;
        if (it.cmd == CMD_BEGIN)
        begin
            cur_x = it.mover_x;
            cur_y = it.mover_y;
            // configured size wins unless both components are zero
            if (cfg_box_w == '0 && cfg_box_h == '0)
            begin
                pass_w = it.mover_w;
                pass_h = it.mover_h;
            end
            else
            begin
                pass_w = cfg_box_w;
                pass_h = cfg_box_h;
            end
            pass_box_x = as_long(cur_x) + as_long(cfg_off_x);
            pass_box_y = as_long(cur_y) + as_long(cfg_off_y);
        end
        else if (it.tile_solid)
        begin
            tx = as_long(it.tile_x);
            ty = as_long(it.tile_y);
            tw = longint'(it.tile_w);
            th = longint'(it.tile_h);
            bx = pass_box_x;
            by = pass_box_y;
            ew = longint'(pass_w);
            eh = longint'(pass_h);
            // inclusive contact test against the box latched at pass start
            if (bx + ew >= tx && tx + tw >= bx && by + eh >= ty && ty + th >= by)
            begin
                hi  = (bx + ew < tx + tw) ? bx + ew : tx + tw;
                lo  = (bx > tx) ? bx : tx;
                ovx = hi - lo;
                hi  = (by + eh < ty + th) ? by + eh : ty + th;
                lo  = (by > ty) ? by : ty;
                ovy = hi - lo;
                r.hit = 1'b1;
                // smaller overlap wins, tie goes to y
                if (ovx < ovy)
                begin
                    r.moved_axis = AXIS_X;
                    if (bx < tx)
                        cur_x = clamp_coord(tx - ew - as_long(cfg_off_x));
                    else
                        cur_x = clamp_coord(tx + tw - as_long(cfg_off_x));
                end
                else
                begin
                    r.moved_axis = AXIS_Y;
                    if (by < ty)
                        cur_y = clamp_coord(ty - eh - as_long(cfg_off_y));
                    else
                        cur_y = clamp_coord(ty + th - as_long(cfg_off_y));
                end
            end
        end
        r.pos_x = cur_x;
        r.pos_y = cur_y;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Item generation
    // ------------------------------------------------------------------------
    function automatic in_t random_item();
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return in_t'(raw[$bits(in_t)-1:0]);
    endfunction

    function automatic len_t pick_len();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 8)
            return len_t'($urandom_range(0, 3072));
        if (sel == 8)
            return len_t'($urandom);
        return $urandom_range(0, 1) ? LEN_MAX : len_t'(0);
    endfunction

    function automatic coord_t pick_pos();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 14)
            return coord_t'(int'($urandom_range(0, 2 * MOVER_SPAN)) - MOVER_SPAN);
        if (sel < 17)
            return coord_t'($urandom);
        if (sel < 18)
            return coord_t'(as_long(COORD_MAX) - longint'($urandom_range(0, 4096)));
        return coord_t'(as_long(COORD_MIN) + longint'($urandom_range(0, 4096)));
    endfunction

    function automatic in_t make_begin(int x, int y, int w, int h);
        in_t it;
        it = random_item();
        it.cmd     = CMD_BEGIN;
        it.mover_x = coord_t'(x);
        it.mover_y = coord_t'(y);
        it.mover_w = len_t'(w);
        it.mover_h = len_t'(h);
        return it;
    endfunction

    function automatic in_t make_tile(int x, int y, int w, int h, logic solid);
        in_t it;
        it = random_item();
        it.cmd        = CMD_TILE;
        it.tile_x     = coord_t'(x);
        it.tile_y     = coord_t'(y);
        it.tile_w     = len_t'(w);
        it.tile_h     = len_t'(h);
        it.tile_solid = solid;
        return it;
    endfunction

    function automatic in_t gen_begin();
        in_t it;
        it = random_item();
        it.cmd     = CMD_BEGIN;
        it.mover_x = pick_pos();
        it.mover_y = pick_pos();
        it.mover_w = pick_len();
        it.mover_h = pick_len();
        return it;
    endfunction

    // tile placed so that it often touches the current start box
    function automatic in_t gen_near_tile();
        in_t  it;
        len_t w, h;
        it = random_item();
        w  = pick_len();
        h  = pick_len();
        it.cmd        = CMD_TILE;
        it.tile_solid = ($urandom_range(0, 99) < 85);
        it.tile_w     = w;
        it.tile_h     = h;
        it.tile_x = clamp_coord(pass_box_x - longint'(w) - 64 +
                    longint'($urandom_range(0, int'(pass_w) + int'(w) + 128)));
        it.tile_y = clamp_coord(pass_box_y - longint'(h) - 64 +
                    longint'($urandom_range(0, int'(pass_h) + int'(h) + 128)));
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Input channel, register port
    // ------------------------------------------------------------------------
    task automatic send_item(in_t it);
        int gap;
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        resolved_q.push_back(resolve_item(it));
        // end of burst: optional gap with valid low
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (gap_max > 0)
            begin
                gap = $urandom_range(0, gap_max);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (resolved_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input reg_idx_t idx,
                              input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] mask;
        logic [APB_DW-1:0] rd;
        mask = (idx == REG_OFFSET_X || idx == REG_OFFSET_Y) ? 32'h00FF_FFFF : 32'h007F_FFFF;
        apb_access(1'b1, idx, value, rd);
        case (idx)
            REG_OFFSET_X: cfg_off_x = coord_t'(value);
            REG_OFFSET_Y: cfg_off_y = coord_t'(value);
            REG_BOX_W:    cfg_box_w = len_t'(value);
            default:      cfg_box_h = len_t'(value);
        endcase
        // readback of the register just written
        apb_access(1'b0, idx, '0, rd);
        if ((rd & mask) !== (value & mask))
        begin
            $display("%0t: register %s readback: expected %h actual %h",
                     $time, idx.name(), value & mask, rd & mask);
            mismatch_count++;
        end
    endtask

    task automatic apply_config(cfg_t c);
        wait_idle();
        write_reg(REG_OFFSET_X, APB_DW'(as_long(c.off_x)));
        write_reg(REG_OFFSET_Y, APB_DW'(as_long(c.off_y)));
        write_reg(REG_BOX_W, APB_DW'(c.box_w));
        write_reg(REG_BOX_H, APB_DW'(c.box_h));
    endtask

    task automatic run_passes(int count, int noise_pct);
        in_t it;
        repeat (count)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                it = random_item();
            else if (tiles_left == 0)
            begin
                it = gen_begin();
                tiles_left = $urandom_range(1, 12);
            end
            else
            begin
                it = gen_near_tile();
                tiles_left--;
            end
            send_item(it);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // tiles against the all-zero reset box
    task automatic test_tiles_before_begin();
        gap_max = 0;
        rx_mode = RX_OPEN;
        send_item(make_tile(0, 0, 0, 0, 1'b1));
        send_item(make_tile(-100, -10, 300, 20, 1'b1));
        send_item(make_tile(5, 5, 5, 5, 1'b0));
        wait_idle();
    endtask

    // box x 256..1280, y 512..1536 with zero offsets
    task automatic test_directed_geometry();
        send_item(make_begin(256, 512, 1024, 1024));
        send_item(make_tile(1200, 600, 400, 400, 1'b1));
        send_item(make_tile(0, 700, 300, 200, 1'b1));
        send_item(make_tile(500, 1500, 200, 400, 1'b1));
        send_item(make_tile(500, 300, 200, 250, 1'b1));
        send_item(make_tile(1280, 800, 64, 64, 1'b1));
        send_item(make_tile(256, 512, 1024, 1024, 1'b1));
        send_item(make_tile(2000, 2000, 10, 10, 1'b1));
        send_item(make_tile(500, 600, 100, 100, 1'b0));
        send_item(make_begin(COORD_MAX, COORD_MIN, LEN_MAX, LEN_MAX));
        send_item(make_tile(COORD_MIN, COORD_MIN, LEN_MAX, LEN_MAX, 1'b1));
        send_item(make_begin(COORD_MIN, COORD_MAX, 0, 0));
        send_item(make_tile(COORD_MAX, COORD_MAX, LEN_MAX, LEN_MAX, 1'b1));
        wait_idle();
    endtask

    // extreme offsets, size pairs with one zero component
    task automatic test_register_extremes();
        apply_config('{off_x: COORD_MAX, off_y: COORD_MIN, box_w: LEN_MAX, box_h: '0});
        send_item(make_begin(0, 0, 5, 5));
        send_item(make_tile(8388000, -8388608, 1000, 0, 1'b1));
        send_item(make_tile(COORD_MAX, COORD_MIN, LEN_MAX, LEN_MAX, 1'b1));
        apply_config('{off_x: COORD_MIN, off_y: COORD_MAX, box_w: '0, box_h: len_t'(77)});
        send_item(make_begin(-5000, 3000, 9, 9));
        send_item(make_tile(COORD_MIN, COORD_MAX, LEN_MAX, LEN_MAX, 1'b1));
        send_item(make_tile(-8388608, 8388000, 5000, 5000, 1'b1));
        wait_idle();
    endtask

    task automatic test_config_sweep();
        cfg_t setting[6];
        setting[0] = '{off_x: '0, off_y: '0, box_w: '0, box_h: '0};
        setting[1] = '{off_x: COORD_MAX, off_y: COORD_MIN, box_w: LEN_MAX, box_h: LEN_MAX};
        setting[2] = '{off_x: COORD_MIN, off_y: COORD_MAX, box_w: '0, box_h: len_t'(300)};
        setting[3] = '{off_x: coord_t'(-1024), off_y: coord_t'(2048),
                       box_w: len_t'(1536), box_h: '0};
        setting[4] = '{off_x: coord_t'($urandom), off_y: coord_t'($urandom),
                       box_w: len_t'($urandom), box_h: len_t'($urandom)};
        setting[5] = '{off_x: coord_t'(int'($urandom_range(0, 8192)) - 4096),
                       off_y: coord_t'(int'($urandom_range(0, 8192)) - 4096),
                       box_w: '0, box_h: '0};
        gap_max = 2;
        rx_mode = RX_RANDOM;
        foreach (setting[i])
        begin
            apply_config(setting[i]);
            run_passes(100, 5);
        end
        wait_idle();
    endtask

    // bursts and gaps on the input against stall patterns on the output
    task automatic test_bursty_flow();
        apply_config('{off_x: coord_t'(int'($urandom_range(0, 8192)) - 4096),
                       off_y: coord_t'(int'($urandom_range(0, 8192)) - 4096),
                       box_w: len_t'($urandom_range(0, 2048)), box_h: '0});
        gap_max = 6;
        rx_mode = RX_PATTERN;
        run_passes(250, 10);
        gap_max = 3;
        rx_mode = RX_RANDOM;
        run_passes(150, 10);
        gap_max = 0;
        rx_mode = RX_OPEN;
        run_passes(100, 10);
        wait_idle();
    endtask

    // long output hold fills the pipeline while the input keeps offering
    task automatic test_backpressure();
        gap_max = 0;
        rx_mode = RX_LONG_HOLD;
        run_passes(200, 5);
        wait_idle();
        rx_mode = RX_OPEN;
    endtask

    task automatic test_noise_items();
        gap_max = 4;
        rx_mode = RX_RANDOM;
        run_passes(100, 60);
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Output stall generator
    // ------------------------------------------------------------------------
    initial
    begin : stall_gen
        int phase;
        phase = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            phase = phase + 1;
            case (rx_mode)
                RX_OPEN:    out_stall <= 1'b0;
                RX_RANDOM:  out_stall <= ($urandom_range(0, 99) < 35);
                RX_PATTERN: out_stall <= ((phase % 7) < 3);
                default:    out_stall <= ((phase % 160) < 120);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: one expectation per transfer out
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (resolved_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %h", $time, out_data);
                mismatch_count++;
            end
            else
            begin
                want = resolved_q.pop_front();
                if (out_data.pos_x !== want.pos_x)
                begin
                    $display("%0t: pos_x: expected %0d actual %0d",
                             $time, want.pos_x, out_data.pos_x);
                    mismatch_count++;
                end
                if (out_data.pos_y !== want.pos_y)
                begin
                    $display("%0t: pos_y: expected %0d actual %0d",
                             $time, want.pos_y, out_data.pos_y);
                    mismatch_count++;
                end
                if (out_data.hit !== want.hit)
                begin
                    $display("%0t: hit: expected %0d actual %0d",
                             $time, want.hit, out_data.hit);
                    mismatch_count++;
                end
                if (out_data.moved_axis !== want.moved_axis)
                begin
                    $display("%0t: moved_axis: expected %0d actual %0d",
                             $time, want.moved_axis, out_data.moved_axis);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Run limit
    // ------------------------------------------------------------------------
    initial
    begin
        #2_000_000;
        $display("FAIL aabb_tile_push_out_unit");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_tiles_before_begin();
        test_directed_geometry();
        test_register_extremes();
        test_config_sweep();
        test_bursty_flow();
        test_backpressure();
        test_noise_items();

        wait_idle();
        if (mismatch_count == 0)
            $display("PASS aabb_tile_push_out_unit");
        else
            $display("FAIL aabb_tile_push_out_unit");
        $finish;
    end

endmodule

>>> files.f
rtl/aabb_tpo_pkg.sv
rtl/aabb_tpo_regs.sv
rtl/aabb_tpo_front.sv
rtl/aabb_tpo_geom.sv
rtl/aabb_tpo_resolve.sv
rtl/aabb_tile_push_out_unit.sv
bench/aabb_tile_push_out_unit_tb.sv
